[src/vgm_register_log_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the register log encoder
// Clocked on clock; the checked forms are held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef VGM_REGISTER_LOG_ENCODER_ASSERT_SVH
`define VGM_REGISTER_LOG_ENCODER_ASSERT_SVH

// Same-cycle implication, off during reset
`define VGM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vgm encoder check failed");

// Next-cycle implication, off during reset
`define VGM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vgm encoder check failed");

// Next-cycle implication that also holds across reset
`define VGM_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("vgm encoder check failed");

`endif

[src/vgmenc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgmenc_pkg
// Shared types and constants of the register log encoder.
// ----------------------------------------------------------------------------
package vgmenc_pkg;

   // Field widths
   localparam int DELAY_W = 22;
   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 32;
   localparam int CHUNK_W = 16;

   // Wait chunk limits and frame lengths
   localparam int CHUNK_LIMIT = 65535;
   localparam logic [CHUNK_W-1:0] NTSC_FRAME = 16'd735;
   localparam logic [CHUNK_W-1:0] PAL_FRAME  = 16'd882;

   // Command bytes
   localparam logic [BYTE_W-1:0] CMD_WAIT_N    = 8'h61;
   localparam logic [BYTE_W-1:0] CMD_WAIT_NTSC = 8'h62;
   localparam logic [BYTE_W-1:0] CMD_WAIT_PAL  = 8'h63;
   localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h5A;
   localparam logic [BYTE_W-1:0] CMD_END       = 8'h66;

   // Command lengths in bytes
   localparam logic [1:0] LEN_SHORT = 2'd1;
   localparam logic [1:0] LEN_LONG  = 2'd3;

   // Defaults for top-level parameters
   localparam int MAX_WAIT_CHUNKS_DEFAULT = 63;
   localparam int QUEUE_DEPTH_DEFAULT     = 2;

   // Input transfer
   typedef struct packed {
      logic               action;
      logic [DELAY_W-1:0] delay;
      logic [BYTE_W-1:0]  reg_req;
      logic [BYTE_W-1:0]  val;
   } req_type;

   // Result transfer
   typedef struct packed {
      logic [BYTE_W-1:0]  command;
      logic [BYTE_W-1:0]  arg_first;
      logic [BYTE_W-1:0]  arg_second;
      logic [1:0]         command_length;
      logic [TOTAL_W-1:0] sample_sum;
      logic [TOTAL_W-1:0] total_bytes;
      logic               last;
   } rsp_type;

   // Job class decided by the front end
   typedef enum logic [1:0] {
      JOB_WAIT,
      JOB_WRITE,
      JOB_END
   } job_kind_type;

   // Job passed from front end to back end
   typedef struct packed {
      job_kind_type       kind;
      logic [DELAY_W-1:0] delay;
      logic [BYTE_W-1:0]  reg_addr;
      logic [BYTE_W-1:0]  value;
   } job_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WAIT,
      BK_WRITE,
      BK_END
   } back_state_type;

endpackage

[src/vgmenc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgmenc_front
// Accepts input items, saturates the delay and classifies each into a job.
// ----------------------------------------------------------------------------
module vgmenc_front #(
   parameter int MAX_WAIT_CHUNKS = vgmenc_pkg::MAX_WAIT_CHUNKS_DEFAULT
) (
   input  logic                  push,
   output logic                  full,
   input  vgmenc_pkg::req_type   req_data,
   output logic                  job_push,
   input  logic                  job_full,
   output vgmenc_pkg::job_type   job_data
);
   import vgmenc_pkg::*;

   localparam logic [DELAY_W-1:0] MAX_DELAY = DELAY_W'(MAX_WAIT_CHUNKS * CHUNK_LIMIT);

   logic [DELAY_W-1:0] sat_delay;

   // Clamp the delay to the chunk budget
   assign sat_delay = (req_data.delay > MAX_DELAY) ? MAX_DELAY : req_data.delay;

   // Classify: finish, write only, or waits then write
   always_comb begin
      job_data.delay    = sat_delay;
      job_data.reg_addr = req_data.reg_req;
      job_data.value    = req_data.val;
      if (req_data.action) begin
         job_data.kind = JOB_END;
      end else if (sat_delay == '0) begin
         job_data.kind = JOB_WRITE;
      end else begin
         job_data.kind = JOB_WAIT;
      end
   end

   // Transfer goes straight into the job queue
   assign job_push = push && !job_full;
   assign full     = job_full;

endmodule

[src/vgmenc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgmenc_queue
// Small job queue between front and back end (depth >= 2).
// ----------------------------------------------------------------------------
module vgmenc_queue #(
   parameter int DEPTH = vgmenc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  vgmenc_pkg::job_type wr_data,
   output logic                q_full,
   input  logic                rd_en,
   output vgmenc_pkg::job_type rd_data,
   output logic                q_empty
);
   import vgmenc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_full  = (count_ff == FULL_CNT);
   assign q_empty = (count_ff == '0);
   assign rd_data = entries_ff[rd_ptr_ff];

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[src/vgmenc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgmenc_back
// Sequencer that expands one job into wait, write and end commands,
// keeps the running totals and holds the result register.
// ----------------------------------------------------------------------------
module vgmenc_back (
   input  logic                clock,
   input  logic                reset,
   input  vgmenc_pkg::job_type job_data,
   input  logic                job_empty,
   output logic                job_pop,
   output logic                empty,
   input  logic                pop,
   output vgmenc_pkg::rsp_type rsp_data
);
   import vgmenc_pkg::*;

   localparam logic [DELAY_W-1:0] CHUNK_MAX = DELAY_W'(CHUNK_LIMIT);

   back_state_type     state_ff, state_in;
   logic [DELAY_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0]  reg_ff, reg_in;
   logic [BYTE_W-1:0]  val_ff, val_in;
   logic [TOTAL_W-1:0] samples_ff, samples_in;
   logic [TOTAL_W-1:0] bytes_ff, bytes_in;
   rsp_type            rsp_ff, rsp_in;
   logic               out_valid_ff, out_valid_in;

   logic               emit;
   logic               load;
   logic               big_chunk;
   logic [CHUNK_W-1:0] chunk;
   logic [CHUNK_W-1:0] add_samples;
   logic [BYTE_W-1:0]  cmd;
   logic [BYTE_W-1:0]  arg1;
   logic [BYTE_W-1:0]  arg2;
   logic [1:0]         len;
   logic               is_last;

   // Handshake between sequencer and result register
   assign emit    = (state_ff != BK_IDLE) && (!out_valid_ff || pop);
   assign load    = (state_ff == BK_IDLE) && !job_empty;
   assign job_pop = load;

   // Next wait chunk
   assign big_chunk = (rem_ff > CHUNK_MAX);
   assign chunk     = big_chunk ? CHUNK_W'(CHUNK_LIMIT) : rem_ff[CHUNK_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         BK_IDLE: begin
            if (load) begin
               unique case (job_data.kind)
                  JOB_WAIT:  state_in = BK_WAIT;
                  JOB_WRITE: state_in = BK_WRITE;
                  JOB_END:   state_in = BK_END;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_WAIT: begin
            if (emit && !big_chunk) begin
               state_in = BK_WRITE;
            end
         end
         BK_WRITE, BK_END: begin
            if (emit) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Command fields for the current state
   always_comb begin
      cmd         = CMD_END;
      arg1        = '0;
      arg2        = '0;
      len         = LEN_SHORT;
      is_last     = 1'b0;
      add_samples = '0;
      unique case (state_ff)
         BK_WAIT: begin
            add_samples = chunk;
            if (chunk == NTSC_FRAME) begin
               cmd = CMD_WAIT_NTSC;
            end else if (chunk == PAL_FRAME) begin
               cmd = CMD_WAIT_PAL;
            end else begin
               cmd  = CMD_WAIT_N;
               arg1 = chunk[7:0];
               arg2 = chunk[15:8];
               len  = LEN_LONG;
            end
         end
         BK_WRITE: begin
            cmd     = CMD_WRITE;
            arg1    = reg_ff;
            arg2    = val_ff;
            len     = LEN_LONG;
            is_last = 1'b1;
         end
         BK_END: begin
            is_last = 1'b1;
         end
         default: begin
            cmd = CMD_END;
         end
      endcase
   end

   // Job registers, totals and result register
   always_comb begin
      rem_in       = rem_ff;
      reg_in       = reg_ff;
      val_in       = val_ff;
      samples_in   = samples_ff;
      bytes_in     = bytes_ff;
      rsp_in       = rsp_ff;
      out_valid_in = out_valid_ff && !pop;
      if (load) begin
         rem_in = job_data.delay;
         reg_in = job_data.reg_addr;
         val_in = job_data.value;
      end
      if (emit) begin
         rem_in                = rem_ff - DELAY_W'(add_samples);
         samples_in            = samples_ff + TOTAL_W'(add_samples);
         bytes_in              = bytes_ff + TOTAL_W'(len);
         rsp_in.command        = cmd;
         rsp_in.arg_first      = arg1;
         rsp_in.arg_second     = arg2;
         rsp_in.command_length = len;
         rsp_in.sample_sum     = samples_in;
         rsp_in.total_bytes    = bytes_in;
         rsp_in.last           = is_last;
         out_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         samples_ff   <= '0;
         bytes_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         samples_ff   <= samples_in;
         bytes_ff     <= bytes_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      reg_ff <= reg_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

[src/vgm_register_log_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_register_log_encoder
// Turns timed register writes into a VGM command stream with running totals.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Moves
//  request   push, full, req_data       one register write or finish item
//  response  empty, pop, rsp_data       one VGM command with totals
//
//  A write with n wait chunks occupies the back-end sequencer for a job
//  load, then one state per command (n waits and a write); a finish item
//  takes a job load and an end command.
//  Reset is synchronous: totals return to zero, queue and result are empty.
//  While pop is low the result holds, the sequencer stops, the job queue
//  fills and full rises; items are still taken while the queue has room.
// ----------------------------------------------------------------------------
module vgm_register_log_encoder #(
   parameter int MAX_WAIT_CHUNKS = vgmenc_pkg::MAX_WAIT_CHUNKS_DEFAULT,  // 1..63
   parameter int QUEUE_DEPTH     = vgmenc_pkg::QUEUE_DEPTH_DEFAULT       // >= 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  vgmenc_pkg::req_type req_data,
   output logic                empty,
   input  logic                pop,
   output vgmenc_pkg::rsp_type rsp_data
);
   import vgmenc_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;

   // Front end: saturate and classify
   vgmenc_front #(
      .MAX_WAIT_CHUNKS (MAX_WAIT_CHUNKS)
   ) u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (job_push),
      .job_full (job_full),
      .job_data (front_job)
   );

   // Job queue
   vgmenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (front_job),
      .q_full  (job_full),
      .rd_en   (job_pop),
      .rd_data (head_job),
      .q_empty (job_empty)
   );

   // Back end: command sequencer and result register
   vgmenc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[src/vgmenc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgmenc_checker
// Port-level checks of the encoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "vgm_register_log_encoder_assert.svh"

module vgmenc_checker (
   input logic                clock,
   input logic                reset,
   input logic                empty,
   input logic                pop,
   input vgmenc_pkg::rsp_type rsp_data
);
   import vgmenc_pkg::*;

   logic [TOTAL_W-1:0] prev_bytes_ff, prev_bytes_in;

   // Byte total of the last result transferred out
   always_comb begin
      prev_bytes_in = prev_bytes_ff;
      if (pop && !empty) begin
         prev_bytes_in = rsp_data.total_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_bytes_ff <= '0;
      end else begin
         prev_bytes_ff <= prev_bytes_in;
      end
   end

   // Nothing is offered right after reset
   `VGM_ASSERT_ALWAYS_NEXT(a_empty_after_reset, reset, empty)

   // A stalled result stays put
   `VGM_ASSERT_NEXT(a_hold_on_stall, !empty && !pop, !empty && $stable(rsp_data))

   // Byte total advances by exactly the shown command's length
   `VGM_ASSERT_IMPL(a_byte_total, !empty, rsp_data.total_bytes == prev_bytes_ff + TOTAL_W'(rsp_data.command_length))

   // Three-byte commands are exactly the counted wait and the write
   `VGM_ASSERT_IMPL(a_length_match, !empty, (rsp_data.command_length == LEN_LONG) == (rsp_data.command == CMD_WAIT_N || rsp_data.command == CMD_WRITE))

   // Only a write or an end command closes an item
   `VGM_ASSERT_IMPL(a_last_kind, !empty && rsp_data.last, rsp_data.command == CMD_WRITE || rsp_data.command == CMD_END)

endmodule

bind vgm_register_log_encoder vgmenc_checker u_checker (.*);
